FILE: src/tlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tlc_pkg;

    localparam int WINDOW    = 32;
    localparam int CHANNELS  = 8;
    localparam int FRAC_BITS = 24;

    localparam int VW     = 48;
    localparam int CHW    = 3;
    localparam int CFGW   = 48;
    localparam int CFG_IW = 2;
    localparam int NW     = $clog2(WINDOW + 1);
    localparam int IW     = $clog2(WINDOW);
    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int AW     = $clog2(DEPTH);

    // sum, sum of squares, scaled variance, deviation
    localparam int SW  = VW + IW;
    localparam int QW  = 2 * VW - 1 + IW;
    localparam int DW  = QW + IW;
    localparam int DVW = SW + 2;

    // digit-serial multiplier
    localparam int MDIG   = 8;
    localparam int MSTEPS = (DVW - 1 + MDIG - 1) / MDIG;
    localparam int MBW    = MSTEPS * MDIG;
    localparam int PW     = (DW + 8 > 2 * DVW) ? DW + 8 : 2 * DVW;

    localparam logic [CFG_IW-1:0] CFG_HIST  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MINH  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FLOOR = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_SIGMA = 2'd3;

    localparam logic [5:0]  RST_HIST  = 6'd32;
    localparam logic [5:0]  RST_MINH  = 6'd10;
    localparam logic [47:0] RST_FLOOR = 48'd2814750;
    localparam logic [7:0]  RST_SIGMA = 8'd9;

    localparam logic [CHW-1:0] CH_LAT   = 3'd0;
    localparam logic [CHW-1:0] CH_LON   = 3'd1;
    localparam logic [CHW-1:0] CH_ROLL  = 3'd2;
    localparam logic [CHW-1:0] CH_PITCH = 3'd3;
    localparam logic [CHW-1:0] CH_YAW   = 3'd4;
    localparam logic [CHW-1:0] CH_ALT   = 3'd5;
    localparam logic [CHW-1:0] CH_PRES  = 3'd6;
    localparam logic [CHW-1:0] CH_TEMP  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_RD, S_ACC, S_MSTART, S_MWAIT, S_DIV, S_LATE, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MOP_SQX, MOP_NQ, MOP_SS, MOP_FLR, MOP_NV, MOP_DEV, MOP_SD
    } t_mop;

    typedef struct packed {
        logic load;
        logic init_acc;
        logic rd;
        logic acc_x;
        logic mul_start;
        logic cap;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic late;
        logic out_load;
        t_mop mop;
    } t_cmd;

    typedef struct packed {
        logic test_ok;
        logic last;
        logic mul_busy;
        logic gt_floor;
        logic gt_dev;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/telemetry_outlier_cleaner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake               payload
// in        i_in_valid/o_in_stall   i_channel, i_sample_value
// out       o_out_valid/i_out_stall o_out_channel, o_clean_value, o_range_fixed,
//                                   o_outlier_replaced, o_zero_snapped
// cfg       i_cfg_we                i_cfg_idx, i_cfg_data
//
// one item at a time: with no outlier test the item goes straight to the late rules;
// otherwise the n window entries are read and squared; the test ends if the variance
// is at or below the floor, and the mean takes 53 divider steps and the sign fix-up.
// products come from the 8-bit digit multiplier, one window read per entry.
// synchronous active-low reset clears config to defaults and all window fills.
// a finished item waits in the output register while the next one is accepted.
module telemetry_outlier_cleaner_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [tlc_pkg::CHW-1:0]         i_channel,
    input  wire logic signed [tlc_pkg::VW-1:0]   i_sample_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [tlc_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  wire logic [tlc_pkg::CFGW-1:0]        i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [tlc_pkg::CHW-1:0]         o_out_channel,
    output logic signed [tlc_pkg::VW-1:0]        o_clean_value,
    output logic                                 o_range_fixed,
    output logic                                 o_outlier_replaced,
    output logic                                 o_zero_snapped
);
    import tlc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tlc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_channel          (i_channel),
        .i_sample_value     (i_sample_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_out_channel      (o_out_channel),
        .o_clean_value      (o_clean_value),
        .o_range_fixed      (o_range_fixed),
        .o_outlier_replaced (o_outlier_replaced),
        .o_zero_snapped     (o_zero_snapped)
    );
endmodule
`default_nettype wire

FILE: src/tlc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module tlc_mul (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [tlc_pkg::PW-1:0]  i_a,
    input  wire logic [tlc_pkg::MBW-1:0] i_b,
    output logic      [tlc_pkg::PW-1:0]  o_prod,
    output logic                       o_busy
);
    import tlc_pkg::*;

    localparam int CNTW = $clog2(MSTEPS + 1);

    logic [PW-1:0]   r_acc;
    logic [PW-1:0]   r_a;
    logic [MBW-1:0]  r_b;
    logic [CNTW-1:0] r_cnt;
    logic [PW+MDIG-1:0] pp;

    // one multiplier digit per cycle
    assign pp = r_a * r_b[MDIG-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(MSTEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_cnt != '0) begin
            r_acc <= r_acc + PW'(pp);
            r_a   <= r_a << MDIG;
            r_b   <= r_b >> MDIG;
        end
    end

    assign o_prod = r_acc;
    assign o_busy = (r_cnt != '0);
endmodule
`default_nettype wire

FILE: src/tlc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tlc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tlc_pkg::t_sts i_sts,
    output tlc_pkg::t_cmd      o_cmd
);
    import tlc_pkg::*;

    t_state r_state, n_state;
    t_mop   r_mop, n_mop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mop   <= MOP_SQX;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mop      = r_mop;
        o_cmd      = '0;
        o_cmd.mop  = r_mop;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.test_ok) begin
                    o_cmd.init_acc = 1'b1;
                    n_state        = S_RD;
                end else begin
                    n_state = S_LATE;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_x = 1'b1;
                n_mop       = MOP_SQX;
                n_state     = S_MSTART;
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (!i_sts.mul_busy) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_MSTART;
                    case (r_mop)
                        MOP_SQX: begin
                            if (i_sts.last) n_mop = MOP_NQ;
                            else n_state = S_RD;
                        end
                        MOP_NQ:  n_mop = MOP_SS;
                        MOP_SS:  n_mop = MOP_FLR;
                        MOP_FLR: begin
                            if (i_sts.gt_floor) n_mop = MOP_NV;
                            else n_state = S_LATE;
                        end
                        MOP_NV:  n_mop = MOP_DEV;
                        MOP_DEV: n_mop = MOP_SD;
                        MOP_SD: begin
                            if (i_sts.gt_dev) begin
                                o_cmd.div_init = 1'b1;
                                n_state        = S_DIV;
                            end else begin
                                n_state = S_LATE;
                            end
                        end
                        default: n_state = S_LATE;
                    endcase
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_fin = 1'b1;
                    n_state       = S_LATE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_LATE: begin
                o_cmd.late = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/tlc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tlc_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tlc_pkg::t_cmd                   i_cmd,
    output tlc_pkg::t_sts                        o_sts,
    input  wire logic [tlc_pkg::CHW-1:0]         i_channel,
    input  wire logic signed [tlc_pkg::VW-1:0]   i_sample_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [tlc_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  wire logic [tlc_pkg::CFGW-1:0]        i_cfg_data,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic      [tlc_pkg::CHW-1:0]         o_out_channel,
    output logic signed [tlc_pkg::VW-1:0]        o_clean_value,
    output logic                                 o_range_fixed,
    output logic                                 o_outlier_replaced,
    output logic                                 o_zero_snapped
);
    import tlc_pkg::*;

    localparam longint ONE = longint'(1) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] LAT_MIN  = VW'(-90 * ONE);
    localparam logic signed [VW-1:0] LAT_MAX  = VW'(90 * ONE);
    localparam logic signed [VW-1:0] LON_MIN  = VW'(-180 * ONE);
    localparam logic signed [VW-1:0] LON_MAX  = VW'(180 * ONE);
    localparam logic signed [VW-1:0] ATT_MIN  = VW'(-360 * ONE);
    localparam logic signed [VW-1:0] ATT_MAX  = VW'(360 * ONE);
    localparam logic signed [VW-1:0] ALT_MIN  = VW'(-50000 * ONE);
    localparam logic signed [VW-1:0] ALT_MAX  = VW'(50000 * ONE);
    localparam logic signed [VW-1:0] PRES_MAX = VW'(2000 * ONE);
    localparam logic signed [VW-1:0] PRES_DEF = VW'((4053 * ONE) / 4);
    localparam logic signed [VW-1:0] TEMP_MIN = VW'(-50 * ONE);
    localparam logic signed [VW-1:0] TEMP_MAX = VW'(85 * ONE);
    localparam logic signed [VW-1:0] TEMP_DEF = VW'(25 * ONE);
    localparam logic signed [VW-1:0] SNAP_MAX = VW'((ONE - 1) / 1000);
    localparam logic signed [VW-1:0] SNAP_MIN = VW'(-((ONE - 1) / 1000));
    localparam int DCW = $clog2(SW + 1);

    // configuration
    logic [5:0]  r_hist;
    logic [5:0]  r_minh;
    logic [47:0] r_floor;
    logic [7:0]  r_sigma;

    // per-channel ring pointers
    logic [IW-1:0] r_head [CHANNELS];
    logic [NW-1:0] r_fill [CHANNELS];

    logic [VW-1:0] mem [DEPTH];
    logic signed [VW-1:0] r_rdata;

    // item under work
    logic [CHW-1:0]        r_ch;
    logic                  r_chok;
    logic signed [VW-1:0]  r_v;
    logic                  r_rf;
    logic                  r_orp;
    logic                  r_zs;
    logic [NW-1:0]         r_n;
    logic [IW-1:0]         r_hd;
    logic [IW-1:0]         r_i;
    logic signed [SW-1:0]  r_s;
    logic [QW-1:0]         r_q;
    logic [DW-1:0]         r_d;
    logic signed [DVW-1:0] r_dev;
    logic [PW-1:0]         r_dev2;
    logic [SW-1:0]         r_dvd;
    logic [NW-1:0]         r_rem;
    logic [DCW-1:0]        r_dcnt;

    logic                  r_out_valid;

    logic                  chok_in;
    logic signed [VW-1:0]  rng_v;
    logic                  rng_rf;
    logic signed [VW-1:0]  lt_v;
    logic                  lt_zs;
    logic [NW-1:0]         len_eff;
    logic [NW-1:0]         minh_eff;
    logic [IW-1:0]         rd_idx;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [VW-1:0]         x_mag;
    logic [SW-1:0]         s_mag;
    logic [VW-1:0]         v_mag;
    logic [DVW-2:0]        dev_mag;
    logic [2*NW-1:0]       nn;
    logic [PW-1:0]         mul_a;
    logic [MBW-1:0]        mul_b;
    logic [PW-1:0]         prod;
    logic                  mul_busy;
    logic signed [DVW-1:0] nv_pos;
    logic signed [DVW-1:0] nv;
    logic [NW:0]           div_tmp;
    logic                  div_ge;
    logic signed [VW-1:0]  q_v;
    logic [NW:0]           n_inc;

    tlc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (prod),
        .o_busy  (mul_busy)
    );

    assign chok_in = (int'(i_channel) < CHANNELS);

    // range rules on the incoming item
    always_comb begin
        rng_v  = i_sample_value;
        rng_rf = 1'b0;
        case (i_channel)
            CH_LAT: begin
                if (i_sample_value < LAT_MIN || i_sample_value > LAT_MAX) begin
                    rng_v = '0; rng_rf = 1'b1;
                end
            end
            CH_LON: begin
                if (i_sample_value < LON_MIN || i_sample_value > LON_MAX) begin
                    rng_v = '0; rng_rf = 1'b1;
                end
            end
            CH_ROLL, CH_PITCH, CH_YAW: begin
                if (i_sample_value < ATT_MIN || i_sample_value > ATT_MAX) begin
                    rng_v = '0; rng_rf = 1'b1;
                end
            end
            CH_ALT: begin
                if (i_sample_value < ALT_MIN || i_sample_value > ALT_MAX) begin
                    rng_v = '0; rng_rf = 1'b1;
                end
            end
            CH_PRES: begin
                if (i_sample_value <= 0 || i_sample_value > PRES_MAX) begin
                    rng_v = PRES_DEF; rng_rf = 1'b1;
                end
            end
            default: begin
                if (i_sample_value < TEMP_MIN || i_sample_value > TEMP_MAX) begin
                    rng_v = TEMP_DEF; rng_rf = 1'b1;
                end
            end
        endcase
    end

    // late rules on the value after the outlier test
    always_comb begin
        lt_v  = r_v;
        lt_zs = 1'b0;
        if (r_chok) begin
            case (r_ch)
                CH_ROLL, CH_PITCH, CH_YAW: begin
                    if (r_v != 0 && r_v <= SNAP_MAX && r_v >= SNAP_MIN) begin
                        lt_v = '0; lt_zs = 1'b1;
                    end
                end
                CH_PRES: begin
                    if (r_v <= 0) begin
                        lt_v = PRES_DEF; lt_zs = 1'b1;
                    end
                end
                CH_TEMP: begin
                    if (r_v < TEMP_MIN || r_v > TEMP_MAX) begin
                        lt_v = TEMP_DEF; lt_zs = 1'b1;
                    end
                end
                default: lt_zs = 1'b0;
            endcase
        end
    end

    assign len_eff  = (r_hist == '0) ? NW'(1) :
                      ((int'(r_hist) > WINDOW) ? NW'(WINDOW) : NW'(r_hist));
    assign minh_eff = (r_minh == '0) ? NW'(1) : NW'(r_minh);

    // newest entry first, walking back from the head
    assign rd_idx  = (r_hd > r_i) ? IW'(int'(r_hd) - 1 - int'(r_i))
                                  : IW'(int'(r_hd) + WINDOW - 1 - int'(r_i));
    assign rd_addr = AW'(int'(CW'(r_ch)) * WINDOW + int'(rd_idx));
    assign wr_addr = AW'(int'(CW'(r_ch)) * WINDOW + int'(r_hd));

    assign x_mag   = r_rdata[VW-1] ? VW'(-r_rdata) : VW'(r_rdata);
    assign s_mag   = r_s[SW-1] ? SW'(-r_s) : SW'(r_s);
    assign v_mag   = r_v[VW-1] ? VW'(-r_v) : VW'(r_v);
    assign dev_mag = r_dev[DVW-1] ? (DVW-1)'(-r_dev) : (DVW-1)'(r_dev);
    assign nn      = r_n * r_n;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mop)
            MOP_SQX: begin mul_a = PW'(x_mag);   mul_b = MBW'(x_mag);   end
            MOP_NQ:  begin mul_a = PW'(r_q);     mul_b = MBW'(r_n);     end
            MOP_SS:  begin mul_a = PW'(s_mag);   mul_b = MBW'(s_mag);   end
            MOP_FLR: begin mul_a = PW'(r_floor); mul_b = MBW'(nn);      end
            MOP_NV:  begin mul_a = PW'(v_mag);   mul_b = MBW'(r_n);     end
            MOP_DEV: begin mul_a = PW'(dev_mag); mul_b = MBW'(dev_mag); end
            MOP_SD:  begin mul_a = PW'(r_d);     mul_b = MBW'(r_sigma); end
            default: begin mul_a = '0;           mul_b = '0;            end
        endcase
    end

    assign nv_pos  = DVW'(prod);
    assign nv      = r_v[VW-1] ? -nv_pos : nv_pos;
    assign div_tmp = {r_rem, r_dvd[SW-1]};
    assign div_ge  = (div_tmp >= {1'b0, r_n});
    assign q_v     = VW'(r_dvd);
    assign n_inc   = {1'b0, r_n} + 1'b1;

    assign o_sts.test_ok  = r_chok && (r_n != '0) && (r_n >= minh_eff);
    assign o_sts.last     = (int'(r_i) + 1 == int'(r_n));
    assign o_sts.mul_busy = mul_busy;
    assign o_sts.gt_floor = (PW'(r_d) > prod);
    assign o_sts.gt_dev   = (r_dev2 > prod);
    assign o_sts.div_done = (r_dcnt == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= RST_HIST;
            r_minh  <= RST_MINH;
            r_floor <= RST_FLOOR;
            r_sigma <= RST_SIGMA;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HIST:  r_hist  <= i_cfg_data[5:0];
                CFG_MINH:  r_minh  <= i_cfg_data[5:0];
                CFG_FLOOR: r_floor <= i_cfg_data[47:0];
                CFG_SIGMA: r_sigma <= i_cfg_data[7:0];
                default:   r_hist  <= r_hist;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c] <= '0;
                r_fill[c] <= '0;
            end
        end else if (i_cmd.late && r_chok) begin
            r_head[CW'(r_ch)] <= (int'(r_hd) == WINDOW - 1) ? '0 : r_hd + 1'b1;
            r_fill[CW'(r_ch)] <= (n_inc > {1'b0, len_eff}) ? len_eff : NW'(n_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.late && r_chok) mem[wr_addr] <= lt_v;
        if (i_cmd.rd) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= i_channel;
            r_chok <= chok_in;
            r_v    <= chok_in ? rng_v : i_sample_value;
            r_rf   <= chok_in && rng_rf;
            r_orp  <= 1'b0;
            r_n    <= r_fill[CW'(i_channel)];
            r_hd   <= r_head[CW'(i_channel)];
        end
        if (i_cmd.init_acc) begin
            r_s <= '0;
            r_q <= '0;
            r_i <= '0;
        end
        if (i_cmd.acc_x) r_s <= r_s + SW'(r_rdata);
        if (i_cmd.cap) begin
            case (i_cmd.mop)
                MOP_SQX: begin
                    r_q <= r_q + QW'(prod);
                    r_i <= r_i + 1'b1;
                end
                MOP_NQ:  r_d    <= DW'(prod);
                MOP_SS:  r_d    <= r_d - DW'(prod);
                MOP_NV:  r_dev  <= nv - DVW'(r_s);
                MOP_DEV: r_dev2 <= prod;
                default: r_d    <= r_d;
            endcase
        end
        if (i_cmd.div_init) begin
            r_dvd  <= s_mag;
            r_rem  <= '0;
            r_dcnt <= DCW'(SW);
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_ge ? NW'(div_tmp - {1'b0, r_n}) : NW'(div_tmp);
            r_dvd  <= {r_dvd[SW-2:0], div_ge};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.div_fin) begin
            r_v   <= r_s[SW-1] ? -q_v : q_v;
            r_orp <= 1'b1;
        end
        if (i_cmd.late) begin
            r_v  <= lt_v;
            r_zs <= lt_zs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_channel      <= r_ch;
            o_clean_value      <= r_v;
            o_range_fixed      <= r_rf;
            o_outlier_replaced <= r_orp;
            o_zero_snapped     <= r_zs;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

FILE: bench/tb_telemetry_outlier_cleaner_top.sv
`timescale 1ns / 1ps
module tb_telemetry_outlier_cleaner_top;
    import tlc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_WAIT  = 600;

    typedef struct {
        logic [CHW-1:0] ch;
        logic [VW-1:0]  val;
        logic           rf;
        logic           orp;
        logic           zs;
    } cleaned_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic [CHW-1:0]        in_channel = '0;
    logic signed [VW-1:0]  in_sample = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IW-1:0]     cfg_idx = '0;
    logic [CFGW-1:0]       cfg_data = '0;
    logic                  out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [CHW-1:0]        o_out_channel;
    logic signed [VW-1:0]  o_clean_value;
    logic                  o_range_fixed;
    logic                  o_outlier_replaced;
    logic                  o_zero_snapped;

    telemetry_outlier_cleaner_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_channel(in_channel), .i_sample_value(in_sample),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_out_channel(o_out_channel), .o_clean_value(o_clean_value),
        .o_range_fixed(o_range_fixed), .o_outlier_replaced(o_outlier_replaced),
        .o_zero_snapped(o_zero_snapped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block state
    logic [VW-1:0] win_shadow [CHANNELS][WINDOW];
    int            head_shadow [CHANNELS];
    int            fill_shadow [CHANNELS];
    logic [5:0]    hist_len;
    logic [5:0]    min_hist;
    logic [47:0]   var_floor;
    logic [7:0]    sigma_sq;

    cleaned_t pending_clean[$];
    int  errors = 0;
    int  sent_items = 0;
    int  checked_items = 0;
    int  mean_hits = 0;
    int  range_hits = 0;
    int  late_hits = 0;
    bit  idle_en = 1'b1;

    function automatic longint fx(int k);
        return longint'(k) * (64'sd1 <<< FRAC_BITS);
    endfunction

    function automatic logic [127:0] mag128(longint a);
        return a < 0 ? 128'(-a) : 128'(a);
    endfunction

    function automatic cleaned_t clean_predict(logic [CHW-1:0] ch, logic [VW-1:0] raw);
        longint v, s, dev, x;
        logic [127:0] q, d, ms;
        int n, len, minh, i;
        cleaned_t r;
        v = longint'($signed(raw));
        r.ch = ch; r.rf = 0; r.orp = 0; r.zs = 0;
        n = fill_shadow[ch];
        minh = (min_hist == 0) ? 1 : int'(min_hist);
        len = (hist_len == 0) ? 1 : ((hist_len > WINDOW) ? WINDOW : int'(hist_len));
        case (ch)
            CH_LAT: if (v < fx(-90) || v > fx(90)) begin v = 0; r.rf = 1; end
            CH_LON: if (v < fx(-180) || v > fx(180)) begin v = 0; r.rf = 1; end
            CH_ROLL, CH_PITCH, CH_YAW:
                if (mag128(v) > 128'(fx(360))) begin v = 0; r.rf = 1; end
            CH_ALT: if (mag128(v) > 128'(fx(50000))) begin v = 0; r.rf = 1; end
            CH_PRES: if (v <= 0 || v > fx(2000)) begin v = fx(4053) / 4; r.rf = 1; end
            default: if (v < fx(-50) || v > fx(85)) begin v = fx(25); r.rf = 1; end
        endcase
        if (n >= 1 && n >= minh) begin
            s = 0; q = 0;
            for (i = 0; i < n; i++) begin
                x = longint'($signed(win_shadow[ch][(head_shadow[ch] + WINDOW - 1 - i) % WINDOW]));
                s += x;
                q += mag128(x) * mag128(x);
            end
            ms = mag128(s);
            d = q * 128'(n) - ms * ms;
            if (d > 128'(var_floor) * 128'(n * n)) begin
                dev = longint'(n) * v - s;
                if (mag128(dev) * mag128(dev) > d * 128'(sigma_sq)) begin
                    v = s / longint'(n);
                    r.orp = 1;
                end
            end
        end
        case (ch)
            CH_ROLL, CH_PITCH, CH_YAW:
                if (v != 0 && mag128(v) * 1000 < (128'd1 << FRAC_BITS)) begin
                    v = 0; r.zs = 1;
                end
            CH_PRES: if (v <= 0) begin v = fx(4053) / 4; r.zs = 1; end
            CH_TEMP: if (v < fx(-50) || v > fx(85)) begin v = fx(25); r.zs = 1; end
            default: ;
        endcase
        win_shadow[ch][head_shadow[ch]] = v[VW-1:0];
        head_shadow[ch] = (head_shadow[ch] + 1) % WINDOW;
        n++;
        fill_shadow[ch] = (n > len) ? len : n;
        r.val = v[VW-1:0];
        return r;
    endfunction

    task automatic send_item(logic [CHW-1:0] ch, logic [VW-1:0] val);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_channel <= ch;
        in_sample  <= val;
        do @(posedge i_clk); while (o_in_stall);
        pending_clean.insert(pending_clean.size(), clean_predict(ch, val));
        sent_items++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_clean.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFGW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_HIST:  hist_len  = data[5:0];
            CFG_MINH:  min_hist  = data[5:0];
            CFG_FLOOR: var_floor = data[47:0];
            CFG_SIGMA: sigma_sq  = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [5:0] hl, logic [5:0] mh, logic [47:0] fl, logic [7:0] sg);
        wait_drained();
        write_reg(CFG_HIST, CFGW'(hl));
        write_reg(CFG_MINH, CFGW'(mh));
        write_reg(CFG_FLOOR, CFGW'(fl));
        write_reg(CFG_SIGMA, CFGW'(sg));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [VW-1:0] random_sample(logic [CHW-1:0] ch);
        longint base, noise;
        int pick;
        case (ch)
            CH_LAT:   base = fx(45);
            CH_LON:   base = fx(-120);
            CH_ROLL:  base = fx(10);
            CH_PITCH: base = 0;
            CH_YAW:   base = fx(200);
            CH_ALT:   base = fx(1000);
            CH_PRES:  base = fx(1013);
            default:  base = fx(20);
        endcase
        pick = $urandom_range(0, 99);
        noise = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        if (pick < 6)
            return VW'({$urandom, $urandom});
        else if (pick < 9)
            return VW'(longint'($urandom_range(0, 20000)) - 10000);
        else if (pick < 17)
            return VW'(base + (longint'($urandom_range(0, 1 << 28)) - (1 << 27)) * 16);
        return VW'(base + noise);
    endfunction

    // output side: stall bursts and result checking
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (pending_clean.size() == 0) begin
                    $display("%0t: unexpected item ch %0d val %h", $time, o_out_channel,
                             o_clean_value);
                    errors++;
                end else begin
                    cleaned_t e;
                    e = pending_clean[0];
                    pending_clean.delete(0);
                    checked_items++;
                    if (e.orp) mean_hits++;
                    if (e.rf) range_hits++;
                    if (e.zs) late_hits++;
                    if (o_out_channel !== e.ch) begin
                        $display("%0t: channel exp %0d got %0d", $time, e.ch, o_out_channel);
                        errors++;
                    end
                    if (o_clean_value !== e.val) begin
                        $display("%0t: clean_value exp %h got %h", $time, e.val, o_clean_value);
                        errors++;
                    end
                    if (o_range_fixed !== e.rf) begin
                        $display("%0t: range_fixed exp %b got %b", $time, e.rf, o_range_fixed);
                        errors++;
                    end
                    if (o_outlier_replaced !== e.orp) begin
                        $display("%0t: outlier_replaced exp %b got %b", $time, e.orp,
                                 o_outlier_replaced);
                        errors++;
                    end
                    if (o_zero_snapped !== e.zs) begin
                        $display("%0t: zero_snapped exp %b got %b", $time, e.zs, o_zero_snapped);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_range_edges();
        send_item(CH_LAT, VW'(fx(90)));
        send_item(CH_LAT, VW'(fx(90) + 1));
        send_item(CH_LAT, VW'(fx(-90) - 1));
        send_item(CH_LON, VW'(fx(-180)));
        send_item(CH_LON, VW'(fx(180) + 1));
        send_item(CH_ROLL, 48'h7FFF_FFFF_FFFF);
        send_item(CH_PITCH, 48'h8000_0000_0000);
        send_item(CH_YAW, VW'(fx(-360)));
        send_item(CH_ALT, VW'(fx(50000) + 1));
        send_item(CH_ALT, VW'(fx(-50000)));
        send_item(CH_PRES, '0);
        send_item(CH_PRES, VW'(-1));
        send_item(CH_PRES, VW'(fx(2000)));
        send_item(CH_PRES, VW'(fx(2000) + 1));
        send_item(CH_TEMP, VW'(fx(-50)));
        send_item(CH_TEMP, VW'(fx(85) + 1));
        send_item(CH_TEMP, VW'(fx(-50) - 1));
    endtask

    task automatic test_near_zero_snap();
        // 16777 * 1000 is just below one, 16778 * 1000 is not
        send_item(CH_ROLL, VW'(16777));
        send_item(CH_PITCH, VW'(-16777));
        send_item(CH_YAW, VW'(16778));
        send_item(CH_ROLL, VW'(1));
        send_item(CH_PITCH, '0);
    endtask

    task automatic test_mean_replace();
        int k;
        for (k = 0; k < 10; k++)
            send_item(CH_ALT, VW'((k % 2) ? fx(1) : fx(-1)));
        send_item(CH_ALT, VW'(fx(40000)));
        send_item(CH_ALT, VW'(fx(-1)));
    endtask

    task automatic test_random_phase(int count, bit with_idle);
        int k;
        logic [CHW-1:0] ch;
        idle_en = with_idle;
        for (k = 0; k < count; k++) begin
            if (k % 97 == 60) wait_drained();
            ch = CHW'($urandom_range(0, CHANNELS - 1));
            send_item(ch, random_sample(ch));
        end
    endtask

    task automatic test_shrink_history();
        int k;
        set_config(6'd32, 6'd5, 48'd0, 8'd4);
        for (k = 0; k < 40; k++) send_item(CH_LAT, random_sample(CH_LAT));
        set_config(6'd3, 6'd2, 48'd0, 8'd4);
        for (k = 0; k < 20; k++) send_item(CH_LAT, random_sample(CH_LAT));
    endtask

    initial begin
        hist_len = RST_HIST; min_hist = RST_MINH; var_floor = RST_FLOOR; sigma_sq = RST_SIGMA;
        for (int c = 0; c < CHANNELS; c++) begin
            head_shadow[c] = 0;
            fill_shadow[c] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_edges();
        test_near_zero_snap();
        test_mean_replace();
        test_random_phase(240, 1'b1);
        set_config(6'd1, 6'd1, 48'd0, 8'd1);
        test_random_phase(180, 1'b1);
        set_config(6'd0, 6'd0, 48'd0, 8'd0);
        test_random_phase(120, 1'b1);
        set_config(6'd4, 6'd2, 48'd0, 8'd3);
        test_random_phase(200, 1'b1);
        set_config(6'd63, 6'd63, 48'hFFFF_FFFF_FFFF, 8'd255);
        test_random_phase(150, 1'b1);
        test_shrink_history();
        set_config(6'd8, 6'd4, 48'd1000, 8'd9);
        test_random_phase(220, 1'b1);
        set_config(6'd32, 6'd10, 48'd2814750, 8'd9);
        test_random_phase(240, 1'b0);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("covered %0d items over 8 register settings, %0d results checked",
                 sent_items, checked_items);
        $display("range fixes %0d, mean replacements %0d, late rule changes %0d",
                 range_hits, mean_hits, late_hits);
        if (errors == 0 && pending_clean.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
